@@ hdl/sprite_frame_sequencer_defines.svh @@
// Assertion macros used by the sprite frame sequencer datapath.
`ifndef SPRITE_FRAME_SEQUENCER_DEFINES_SVH
`define SPRITE_FRAME_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define SFS_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sprite frame sequencer: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define SFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sprite frame sequencer: next-cycle check failed");

`endif

@@ hdl/sfs_pkg.sv @@
// Types and constants of the sprite frame sequencer.
`timescale 1ns / 1ps
package sfs_pkg;

  localparam int unsigned FRAME_W = 8;
  localparam int unsigned COLS_W  = 9;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ACC_W   = 33;

  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_REG     = 3'd1,
    KIND_CREATE  = 3'd2,
    KIND_DESTROY = 3'd3,
    KIND_RECT    = 3'd4,
    KIND_STOPQ   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_BAD_ID    = 2'd2,
    STAT_ZERO_COLS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_SLOT = 2'd1,
    RES_RECT = 2'd2,
    RES_STOP = 2'd3
  } res_sel_e;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        slot_index;
    logic [11:0]       texture_id;
    logic [8:0]        pattern_count;
    logic [COLS_W-1:0] columns;
    logic [TIME_W-1:0] time_value;
    logic [11:0]       cell_width;
    logic [11:0]       cell_height;
    logic [11:0]       start_x;
    logic [11:0]       start_y;
    logic              looped;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  new_slot;
    logic [11:0] out_texture;
    logic [19:0] src_x;
    logic [19:0] src_y;
    logic [11:0] src_width;
    logic [11:0] src_height;
    logic        stopped;
  } out_t;

  typedef struct packed {
    logic [11:0]        texture;
    logic [FRAME_W-1:0] count_m1;
    logic [COLS_W-1:0]  cols;
    logic [11:0]        cell_w;
    logic [11:0]        cell_h;
    logic [11:0]        org_x;
    logic [11:0]        org_y;
    logic               loop;
    logic [TIME_W-1:0]  period;
  } pat_entry_t;

  typedef struct packed {
    logic     in_ready;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     scan_ply;
    logic     ply_rd;
    logic     use_item;
    logic     pat_rd;
    logic     pat_wr;
    logic     ply_create;
    logic     ply_destroy;
    logic     adv;
    logic     acc_wr;
    logic     div_start;
    logic     mul;
    logic     res_cap;
    res_sel_e res_sel;
    status_e  res_status;
    logic     res_push;
  } cmd_t;

  typedef struct packed {
    logic       in_fire;
    logic [2:0] kind;
    logic       scan_free;
    logic       scan_last;
    logic       walk_live;
    logic       walk_last;
    logic       ply_live;
    logic       pat_ok;
    logic       cols_zero;
    logic       div_busy;
    logic       out_free;
  } stat_t;

endpackage

@@ hdl/sfs_stream_if.sv @@
// Valid/ready request channel carrying one payload.
`timescale 1ns / 1ps
interface sfs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/sfs_divider.sv @@
// Restoring divider for frame number by sheet columns, one quotient bit per cycle.
`timescale 1ns / 1ps
module sfs_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sfs_pkg::FRAME_W-1:0] dividend_i,
  input  logic [sfs_pkg::COLS_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic [sfs_pkg::FRAME_W-1:0] quotient_o,
  output logic [sfs_pkg::FRAME_W-1:0] remainder_o
);
  localparam int unsigned STEP_W = $clog2(sfs_pkg::FRAME_W);

  logic                        busy_q;
  logic [STEP_W-1:0]           step_q;
  logic [sfs_pkg::FRAME_W-1:0] quo_q;
  logic [sfs_pkg::COLS_W-1:0]  rem_q;
  logic [sfs_pkg::COLS_W-1:0]  dvs_q;
  logic [sfs_pkg::COLS_W:0]    trial;
  logic                        ge;

  assign trial = {rem_q, quo_q[sfs_pkg::FRAME_W-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STEP_W'(sfs_pkg::FRAME_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[sfs_pkg::FRAME_W-2:0], ge};
      rem_q <= ge ? sfs_pkg::COLS_W'(trial - {1'b0, dvs_q})
                  : trial[sfs_pkg::COLS_W-1:0];
    end
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q[sfs_pkg::FRAME_W-1:0];
endmodule

@@ hdl/sfs_ctrl.sv @@
// Controller state machine of the sprite frame sequencer.
`timescale 1ns / 1ps
module sfs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sfs_pkg::stat_t stat_i,
  output sfs_pkg::cmd_t  cmd_o
);
  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_SCAN   = 16'h0002,
    ST_CREATE = 16'h0004,
    ST_DROP   = 16'h0008,
    ST_STOPQ  = 16'h0010,
    ST_WALK   = 16'h0020,
    ST_WPAT   = 16'h0040,
    ST_WADV   = 16'h0080,
    ST_WACC   = 16'h0100,
    ST_RRD    = 16'h0200,
    ST_RPAT   = 16'h0400,
    ST_RCHK   = 16'h0800,
    ST_RDIV   = 16'h1000,
    ST_RMUL   = 16'h2000,
    ST_RSUM   = 16'h4000,
    ST_RESP   = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic   scan_ply_q, scan_ply_d;

  always_comb begin
    state_d    = state_q;
    scan_ply_d = scan_ply_q;
    cmd_o      = '0;
    cmd_o.res_sel    = sfs_pkg::RES_NONE;
    cmd_o.res_status = sfs_pkg::STAT_OK;
    cmd_o.scan_ply   = scan_ply_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_fire) begin
          cmd_o.cnt_clr = 1'b1;
          case (stat_i.kind)
            sfs_pkg::KIND_TICK:    state_d = ST_WALK;
            sfs_pkg::KIND_REG: begin
              scan_ply_d = 1'b0;
              state_d    = ST_SCAN;
            end
            sfs_pkg::KIND_CREATE:  state_d = ST_CREATE;
            sfs_pkg::KIND_DESTROY: state_d = ST_DROP;
            sfs_pkg::KIND_RECT:    state_d = ST_RRD;
            sfs_pkg::KIND_STOPQ:   state_d = ST_STOPQ;
            default: begin
              cmd_o.res_cap    = 1'b1;
              cmd_o.res_status = sfs_pkg::STAT_BAD_ID;
              state_d          = ST_RESP;
            end
          endcase
        end
      end
      ST_CREATE: begin
        if (stat_i.pat_ok) begin
          scan_ply_d = 1'b1;
          state_d    = ST_SCAN;
        end else begin
          cmd_o.res_cap    = 1'b1;
          cmd_o.res_status = sfs_pkg::STAT_BAD_ID;
          state_d          = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_free) begin
          cmd_o.pat_wr     = !scan_ply_q;
          cmd_o.ply_create = scan_ply_q;
          cmd_o.res_cap    = 1'b1;
          cmd_o.res_sel    = sfs_pkg::RES_SLOT;
          state_d          = ST_RESP;
        end else if (stat_i.scan_last) begin
          cmd_o.res_cap    = 1'b1;
          cmd_o.res_status = sfs_pkg::STAT_FULL;
          state_d          = ST_RESP;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_DROP: begin
        cmd_o.res_cap     = 1'b1;
        cmd_o.ply_destroy = stat_i.ply_live;
        if (!stat_i.ply_live) begin
          cmd_o.res_status = sfs_pkg::STAT_BAD_ID;
        end
        state_d = ST_RESP;
      end
      ST_STOPQ: begin
        cmd_o.res_cap = 1'b1;
        if (stat_i.ply_live) begin
          cmd_o.res_sel = sfs_pkg::RES_STOP;
        end else begin
          cmd_o.res_status = sfs_pkg::STAT_BAD_ID;
        end
        state_d = ST_RESP;
      end
      ST_WALK: begin
        cmd_o.ply_rd = 1'b1;
        if (stat_i.walk_live) begin
          state_d = ST_WPAT;
        end else if (stat_i.walk_last) begin
          cmd_o.res_cap = 1'b1;
          state_d       = ST_RESP;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_WPAT: begin
        cmd_o.pat_rd = 1'b1;
        state_d      = ST_WADV;
      end
      ST_WADV: begin
        cmd_o.adv = 1'b1;
        state_d   = ST_WACC;
      end
      ST_WACC: begin
        cmd_o.acc_wr = 1'b1;
        if (stat_i.walk_last) begin
          cmd_o.res_cap = 1'b1;
          state_d       = ST_RESP;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = ST_WALK;
        end
      end
      ST_RRD: begin
        if (stat_i.ply_live) begin
          cmd_o.ply_rd   = 1'b1;
          cmd_o.use_item = 1'b1;
          state_d        = ST_RPAT;
        end else begin
          cmd_o.res_cap    = 1'b1;
          cmd_o.res_status = sfs_pkg::STAT_BAD_ID;
          state_d          = ST_RESP;
        end
      end
      ST_RPAT: begin
        cmd_o.pat_rd = 1'b1;
        state_d      = ST_RCHK;
      end
      ST_RCHK: begin
        if (stat_i.cols_zero) begin
          cmd_o.res_cap    = 1'b1;
          cmd_o.res_status = sfs_pkg::STAT_ZERO_COLS;
          state_d          = ST_RESP;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_RDIV;
        end
      end
      ST_RDIV: begin
        if (!stat_i.div_busy) begin
          state_d = ST_RMUL;
        end
      end
      ST_RMUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_RSUM;
      end
      ST_RSUM: begin
        cmd_o.res_cap = 1'b1;
        cmd_o.res_sel = sfs_pkg::RES_RECT;
        state_d       = ST_RESP;
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.res_push = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_ply_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_ply_q <= scan_ply_d;
    end
  end
endmodule

@@ hdl/sfs_datapath.sv @@
// Datapath of the sprite frame sequencer: tables, tick arithmetic and rectangle math.
`timescale 1ns / 1ps
`include "sprite_frame_sequencer_defines.svh"
module sfs_datapath #(
  parameter int unsigned PATTERN_SLOTS = 128,
  parameter int unsigned PLAYER_SLOTS  = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  sfs_stream_if.sink     req_i,
  sfs_stream_if.source   rsp_o,
  input  sfs_pkg::cmd_t  cmd_i,
  output sfs_pkg::stat_t stat_o
);
  localparam int unsigned PAT_AW   = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
  localparam int unsigned PLY_AW   = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1;
  localparam int unsigned IDX_W    = (PAT_AW > PLY_AW) ? PAT_AW : PLY_AW;
  localparam int unsigned PAT_SCAN = (PATTERN_SLOTS < 256) ? PATTERN_SLOTS : 256;
  localparam int unsigned PLY_SCAN = (PLAYER_SLOTS < 256) ? PLAYER_SLOTS : 256;

  typedef struct packed {
    logic [PAT_AW-1:0]           pat;
    logic [sfs_pkg::FRAME_W-1:0] frame;
    logic [sfs_pkg::ACC_W-1:0]   accum;
  } ply_entry_t;

  sfs_pkg::in_t        item_q;
  sfs_pkg::out_t       res_q, res_d, out_q;
  logic                out_valid_q;
  logic [IDX_W-1:0]    cnt_q;

  logic [PATTERN_SLOTS-1:0] pat_valid_q;
  logic [PLAYER_SLOTS-1:0]  ply_valid_q;
  logic [PLAYER_SLOTS-1:0]  ply_stop_q;

  sfs_pkg::pat_entry_t pat_mem [PATTERN_SLOTS];
  sfs_pkg::pat_entry_t pat_rd_q;
  ply_entry_t          ply_mem [PLAYER_SLOTS];
  ply_entry_t          ply_rd_q;

  logic [sfs_pkg::FRAME_W-1:0] adv_frame_q;
  logic [sfs_pkg::ACC_W-1:0]   adv_acc_q;
  logic                        adv_stop_q;
  logic [19:0]                 mx_q, my_q;

  logic [PAT_AW-1:0] pat_cnt_idx, pat_item_idx;
  logic [PLY_AW-1:0] ply_cnt_idx, ply_item_idx, ply_rd_idx;
  logic              item_ply_live;
  sfs_pkg::pat_entry_t pat_wdata;
  logic [8:0]        pcount;

  logic                        hit, over;
  logic [sfs_pkg::FRAME_W:0]   nf;
  logic [sfs_pkg::FRAME_W-1:0] frame_d;
  logic [sfs_pkg::ACC_W-1:0]   acc_d, acc_sat;
  logic [sfs_pkg::ACC_W:0]     acc_sum;

  logic                        div_busy;
  logic [sfs_pkg::FRAME_W-1:0] div_quo, div_rem;

  assign pat_cnt_idx   = cnt_q[PAT_AW-1:0];
  assign ply_cnt_idx   = cnt_q[PLY_AW-1:0];
  assign pat_item_idx  = PAT_AW'(item_q.slot_index);
  assign ply_item_idx  = PLY_AW'(item_q.slot_index);
  assign ply_rd_idx    = cmd_i.use_item ? ply_item_idx : ply_cnt_idx;
  assign item_ply_live = (32'(item_q.slot_index) < PLAYER_SLOTS) && ply_valid_q[ply_item_idx];

  assign req_i.ready     = cmd_i.in_ready;
  assign stat_o.in_fire  = req_i.valid && cmd_i.in_ready;
  assign stat_o.kind     = req_i.data.kind;
  assign stat_o.scan_free = cmd_i.scan_ply ? !ply_valid_q[ply_cnt_idx]
                                           : !pat_valid_q[pat_cnt_idx];
  assign stat_o.scan_last = cmd_i.scan_ply ? (cnt_q == IDX_W'(PLY_SCAN - 1))
                                           : (cnt_q == IDX_W'(PAT_SCAN - 1));
  assign stat_o.walk_live = ply_valid_q[ply_cnt_idx];
  assign stat_o.walk_last = (cnt_q == IDX_W'(PLAYER_SLOTS - 1));
  assign stat_o.ply_live  = item_ply_live;
  assign stat_o.pat_ok    = (32'(item_q.slot_index) < PATTERN_SLOTS) && pat_valid_q[pat_item_idx];
  assign stat_o.cols_zero = (pat_rd_q.cols == '0);
  assign stat_o.div_busy  = div_busy;
  assign stat_o.out_free  = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i) begin
    if (stat_o.in_fire) begin
      item_q <= req_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign pcount = item_q.pattern_count;
  always_comb begin
    pat_wdata.texture = item_q.texture_id;
    if (pcount == 9'd0) begin
      pat_wdata.count_m1 = '0;
    end else if (pcount > 9'd256) begin
      pat_wdata.count_m1 = '1;
    end else begin
      pat_wdata.count_m1 = sfs_pkg::FRAME_W'(pcount - 9'd1);
    end
    pat_wdata.cols   = item_q.columns;
    pat_wdata.cell_w = item_q.cell_width;
    pat_wdata.cell_h = item_q.cell_height;
    pat_wdata.org_x  = item_q.start_x;
    pat_wdata.org_y  = item_q.start_y;
    pat_wdata.loop   = item_q.looped;
    pat_wdata.period = item_q.time_value;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pat_wr) begin
      pat_mem[pat_cnt_idx] <= pat_wdata;
    end
    if (cmd_i.pat_rd) begin
      pat_rd_q <= pat_mem[ply_rd_q.pat];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ply_create) begin
      ply_mem[ply_cnt_idx] <= '{pat: PAT_AW'(item_q.slot_index), frame: '0, accum: '0};
    end else if (cmd_i.acc_wr) begin
      ply_mem[ply_cnt_idx] <= '{pat: ply_rd_q.pat, frame: adv_frame_q, accum: acc_sat};
    end
    if (cmd_i.ply_rd) begin
      ply_rd_q <= ply_mem[ply_rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_valid_q <= '0;
      ply_valid_q <= '0;
      ply_stop_q  <= '0;
    end else begin
      if (cmd_i.pat_wr) begin
        pat_valid_q[pat_cnt_idx] <= 1'b1;
      end
      if (cmd_i.ply_create) begin
        ply_valid_q[ply_cnt_idx] <= 1'b1;
        ply_stop_q[ply_cnt_idx]  <= 1'b0;
      end
      if (cmd_i.ply_destroy) begin
        ply_valid_q[ply_item_idx] <= 1'b0;
      end
      if (cmd_i.acc_wr && adv_stop_q) begin
        ply_stop_q[ply_cnt_idx] <= 1'b1;
      end
    end
  end

  // Frame advance uses the accumulator before this tick's elapsed time is added.
  always_comb begin
    hit   = (ply_rd_q.accum >= {1'b0, pat_rd_q.period});
    nf    = {1'b0, ply_rd_q.frame} + 1'b1;
    over  = (nf > {1'b0, pat_rd_q.count_m1});
    frame_d = ply_rd_q.frame;
    if (hit) begin
      if (over) begin
        frame_d = pat_rd_q.loop ? '0 : pat_rd_q.count_m1;
      end else begin
        frame_d = nf[sfs_pkg::FRAME_W-1:0];
      end
    end
    acc_d   = hit ? (ply_rd_q.accum - {1'b0, pat_rd_q.period}) : ply_rd_q.accum;
    acc_sum = {1'b0, adv_acc_q} + (sfs_pkg::ACC_W + 1)'(item_q.time_value);
    acc_sat = acc_sum[sfs_pkg::ACC_W] ? '1 : acc_sum[sfs_pkg::ACC_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.adv) begin
      adv_frame_q <= frame_d;
      adv_acc_q   <= acc_d;
      adv_stop_q  <= hit && over && !pat_rd_q.loop;
    end
    if (cmd_i.mul) begin
      mx_q <= 20'(div_rem) * 20'(pat_rd_q.cell_w);
      my_q <= 20'(div_quo) * 20'(pat_rd_q.cell_h);
    end
  end

  sfs_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (ply_rd_q.frame),
    .divisor_i   (pat_rd_q.cols),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    res_d        = '0;
    res_d.status = cmd_i.res_status;
    case (cmd_i.res_sel)
      sfs_pkg::RES_SLOT: res_d.new_slot = 8'(cnt_q);
      sfs_pkg::RES_RECT: begin
        res_d.out_texture = pat_rd_q.texture;
        res_d.src_x       = 20'(pat_rd_q.org_x) + mx_q;
        res_d.src_y       = 20'(pat_rd_q.org_y) + my_q;
        res_d.src_width   = pat_rd_q.cell_w;
        res_d.src_height  = pat_rd_q.cell_h;
      end
      sfs_pkg::RES_STOP: res_d.stopped = ply_stop_q[ply_item_idx];
      default: res_d.new_slot = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_cap) begin
      res_q <= res_d;
    end
    if (cmd_i.res_push) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_push) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  `SFS_ASSERT_NEXT(a_pat_wr_sets_valid, cmd_i.pat_wr, pat_valid_q[$past(pat_cnt_idx)])
  `SFS_ASSERT_NEXT(a_create_live_running, cmd_i.ply_create, ply_valid_q[$past(ply_cnt_idx)] && !ply_stop_q[$past(ply_cnt_idx)])
  `SFS_ASSERT(a_no_accept_while_dividing, stat_o.in_fire, !div_busy)
endmodule

@@ hdl/sprite_frame_sequencer.sv @@
// Top level of the sprite frame sequencer.
// One request is taken at a time and gives one response; a new request is taken
// while the previous response still waits in the output register. A tick walks
// the player table slot by slot: a free slot is skipped, and a live player is read,
// its pattern read, its frame advanced and the entry written back, the player and
// pattern memories being read one after the other. Register and create scan for
// the lowest free slot one entry per cycle (create first checks the pattern). A
// rectangle query reads player and pattern, runs the 8-step frame/columns divider,
// then multiplies and sums. Patterns are never freed.
`timescale 1ns / 1ps
module sprite_frame_sequencer #(
  parameter int unsigned PATTERN_SLOTS = 128,
  parameter int unsigned PLAYER_SLOTS  = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfs_stream_if.sink   req_i,
  sfs_stream_if.source rsp_o
);
  sfs_pkg::cmd_t  cmd;
  sfs_pkg::stat_t stat;

  sfs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  sfs_datapath #(
    .PATTERN_SLOTS (PATTERN_SLOTS),
    .PLAYER_SLOTS  (PLAYER_SLOTS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );
endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench of the sprite frame sequencer, with a built-in predictor.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned PAT_N = 128;
  localparam int unsigned PLY_N = 256;
  localparam logic [32:0] ACC_SAT = 33'h1_FFFF_FFFF;
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned HOLD_LEN = 400;
  localparam int unsigned ITEMS_PER_PHASE = 480;

  typedef struct {
    logic [11:0] tex;
    logic [8:0]  cnt;
    logic [8:0]  cols;
    logic [11:0] cw;
    logic [11:0] ch;
    logic [11:0] ox;
    logic [11:0] oy;
    logic        loop;
    logic [31:0] period;
  } anim_pat_t;

  typedef struct {
    sfs_pkg::in_t  req;
    bit            typed;
    sfs_pkg::out_t rsp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sfs_stream_if #(.T(sfs_pkg::in_t))  req_if ();
  sfs_stream_if #(.T(sfs_pkg::out_t)) rsp_if ();

  sprite_frame_sequencer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always #4 clk_i = ~clk_i;

  bit          pat_live [PAT_N];
  anim_pat_t   pat_tab [PAT_N];
  bit          ply_live [PLY_N];
  logic [6:0]  ply_pat [PLY_N];
  logic [7:0]  ply_frame [PLY_N];
  logic [32:0] ply_acc [PLY_N];
  bit          ply_stop [PLY_N];

  sfs_pkg::out_t rsp_expected [$];
  int unsigned fail_count = 0;
  int unsigned stall_pct = 0;
  int unsigned idle_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_req = 0;
  int unsigned n_tick = 0;
  int unsigned n_full = 0;
  int unsigned n_zero_cols = 0;
  int unsigned n_stopped = 0;
  stim_row_t   directed [$];

  function automatic sfs_pkg::out_t animate_step(sfs_pkg::in_t r);
    sfs_pkg::out_t o;
    logic [8:0]  nf;
    logic [33:0] sum;
    logic [8:0]  cnt;
    int unsigned p;
    int unsigned f;
    logic [63:0] x;
    logic [63:0] y;
    o = '0;
    case (r.kind)
      sfs_pkg::KIND_TICK: begin
        for (int i = 0; i < PLY_N; i++) begin
          if (!ply_live[i]) continue;
          p = ply_pat[i];
          if (ply_acc[i] >= {1'b0, pat_tab[p].period}) begin
            nf = {1'b0, ply_frame[i]} + 9'd1;
            if (nf >= pat_tab[p].cnt) begin
              if (pat_tab[p].loop) begin
                nf = '0;
              end else begin
                nf = pat_tab[p].cnt - 9'd1;
                ply_stop[i] = 1'b1;
              end
            end
            ply_frame[i] = nf[7:0];
            ply_acc[i] = ply_acc[i] - {1'b0, pat_tab[p].period};
          end
          sum = {1'b0, ply_acc[i]} + {2'b0, r.time_value};
          ply_acc[i] = (sum > {1'b0, ACC_SAT}) ? ACC_SAT : sum[32:0];
        end
      end
      sfs_pkg::KIND_REG: begin
        o.status = sfs_pkg::STAT_FULL;
        for (int i = 0; i < PAT_N; i++) begin
          if (pat_live[i]) continue;
          cnt = r.pattern_count;
          if (cnt == 0) cnt = 9'd1;
          if (cnt > 9'd256) cnt = 9'd256;
          pat_tab[i] = '{r.texture_id, cnt, r.columns, r.cell_width, r.cell_height,
                         r.start_x, r.start_y, r.looped, r.time_value};
          pat_live[i] = 1'b1;
          o.status = sfs_pkg::STAT_OK;
          o.new_slot = i[7:0];
          break;
        end
      end
      sfs_pkg::KIND_CREATE: begin
        if (r.slot_index >= PAT_N || !pat_live[r.slot_index]) begin
          o.status = sfs_pkg::STAT_BAD_ID;
        end else begin
          o.status = sfs_pkg::STAT_FULL;
          for (int i = 0; i < PLY_N; i++) begin
            if (ply_live[i]) continue;
            ply_live[i] = 1'b1;
            ply_pat[i] = r.slot_index[6:0];
            ply_frame[i] = '0;
            ply_acc[i] = '0;
            ply_stop[i] = 1'b0;
            o.status = sfs_pkg::STAT_OK;
            o.new_slot = i[7:0];
            break;
          end
        end
      end
      sfs_pkg::KIND_DESTROY: begin
        if (!ply_live[r.slot_index]) o.status = sfs_pkg::STAT_BAD_ID;
        else ply_live[r.slot_index] = 1'b0;
      end
      sfs_pkg::KIND_RECT: begin
        if (!ply_live[r.slot_index]) begin
          o.status = sfs_pkg::STAT_BAD_ID;
        end else begin
          p = ply_pat[r.slot_index];
          if (pat_tab[p].cols == 0) begin
            o.status = sfs_pkg::STAT_ZERO_COLS;
          end else begin
            f = ply_frame[r.slot_index];
            x = 64'(pat_tab[p].ox) + 64'(f % pat_tab[p].cols) * 64'(pat_tab[p].cw);
            y = 64'(pat_tab[p].oy) + 64'(f / pat_tab[p].cols) * 64'(pat_tab[p].ch);
            o.out_texture = pat_tab[p].tex;
            o.src_x = x[19:0];
            o.src_y = y[19:0];
            o.src_width = pat_tab[p].cw;
            o.src_height = pat_tab[p].ch;
          end
        end
      end
      sfs_pkg::KIND_STOPQ: begin
        if (!ply_live[r.slot_index]) o.status = sfs_pkg::STAT_BAD_ID;
        else o.stopped = ply_stop[r.slot_index];
      end
      default: o.status = sfs_pkg::STAT_BAD_ID;
    endcase
    return o;
  endfunction

  function automatic sfs_pkg::in_t make_req(logic [2:0] kind, logic [7:0] idx,
                                            logic [11:0] tex, logic [8:0] cnt,
                                            logic [8:0] cols, logic [31:0] tv,
                                            logic [11:0] cw, logic [11:0] ch,
                                            logic [11:0] sx, logic [11:0] sy, logic lp);
    sfs_pkg::in_t r;
    r = '{kind, idx, tex, cnt, cols, tv, cw, ch, sx, sy, lp};
    return r;
  endfunction

  function automatic sfs_pkg::out_t make_rsp(sfs_pkg::status_e st, logic [7:0] slot);
    sfs_pkg::out_t o;
    o = '0;
    o.status = st;
    o.new_slot = slot;
    return o;
  endfunction

  function automatic sfs_pkg::in_t random_req();
    sfs_pkg::in_t r;
    logic [127:0] raw;
    int unsigned pick;
    raw = {$urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(sfs_pkg::in_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 15) r.kind = sfs_pkg::KIND_TICK;
    else if (pick < 30) r.kind = sfs_pkg::KIND_REG;
    else if (pick < 60) r.kind = sfs_pkg::KIND_CREATE;
    else if (pick < 72) r.kind = sfs_pkg::KIND_DESTROY;
    else if (pick < 87) r.kind = sfs_pkg::KIND_RECT;
    else if (pick < 97) r.kind = sfs_pkg::KIND_STOPQ;
    else r.kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_7 : KIND_SPARE_6;
    if (r.kind == sfs_pkg::KIND_CREATE && $urandom_range(0, 9) < 8)
      r.slot_index = 8'($urandom_range(0, PAT_N - 1));
    if ($urandom_range(0, 9) < 8) begin
      r.pattern_count = 9'($urandom_range(1, 8));
      r.columns = 9'($urandom_range(0, 6));
      r.time_value = (r.kind == sfs_pkg::KIND_TICK) ? $urandom_range(0, 32'h4_0000)
                                                    : $urandom_range(0, 32'h3_0000);
    end
    if ($urandom_range(0, 19) == 0) r.time_value = 32'hFFFF_FFFF;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    fail_count++;
  endtask

  task automatic send_request(sfs_pkg::in_t r, bit typed, sfs_pkg::out_t typed_rsp);
    sfs_pkg::out_t pred;
    req_if.valid = 1'b1;
    req_if.data = r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pred = animate_step(r);
    n_req++;
    if (r.kind == sfs_pkg::KIND_TICK) n_tick++;
    if (pred.status == sfs_pkg::STAT_FULL) n_full++;
    if (pred.status == sfs_pkg::STAT_ZERO_COLS) n_zero_cols++;
    if (pred.stopped) n_stopped++;
    rsp_expected.push_back(typed ? typed_rsp : pred);
    @(negedge clk_i);
  endtask

  task automatic idle_sender();
    while ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (rsp_expected.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready = 1'b0;
    end else begin
      rsp_if.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    sfs_pkg::out_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      if (rsp_expected.size() == 0) begin
        $display("%0t ns: response arrived with no request outstanding", $time);
        fail_count++;
      end else begin
        want = rsp_expected.pop_front();
        if (rsp_if.data.status !== want.status)
          report_mismatch("status", rsp_if.data.status, want.status);
        if (rsp_if.data.new_slot !== want.new_slot)
          report_mismatch("new_slot", rsp_if.data.new_slot, want.new_slot);
        if (rsp_if.data.out_texture !== want.out_texture)
          report_mismatch("out_texture", rsp_if.data.out_texture, want.out_texture);
        if (rsp_if.data.src_x !== want.src_x)
          report_mismatch("src_x", rsp_if.data.src_x, want.src_x);
        if (rsp_if.data.src_y !== want.src_y)
          report_mismatch("src_y", rsp_if.data.src_y, want.src_y);
        if (rsp_if.data.src_width !== want.src_width)
          report_mismatch("src_width", rsp_if.data.src_width, want.src_width);
        if (rsp_if.data.src_height !== want.src_height)
          report_mismatch("src_height", rsp_if.data.src_height, want.src_height);
        if (rsp_if.data.stopped !== want.stopped)
          report_mismatch("stopped", rsp_if.data.stopped, want.stopped);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Timeout with %0d responses outstanding.", rsp_expected.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;

    directed.push_back('{make_req(sfs_pkg::KIND_TICK, 0, 0, 0, 0, 32'h1_0000, 0, 0, 0, 0, 0),
                         1, make_rsp(sfs_pkg::STAT_OK, 0)});
    directed.push_back('{make_req(KIND_SPARE_6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         make_rsp(sfs_pkg::STAT_BAD_ID, 0)});
    directed.push_back('{make_req(KIND_SPARE_7, 8'hFF, 12'hFFF, 9'h1FF, 9'h1FF,
                         32'hFFFF_FFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1), 1,
                         make_rsp(sfs_pkg::STAT_BAD_ID, 0)});
    directed.push_back('{make_req(sfs_pkg::KIND_CREATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         make_rsp(sfs_pkg::STAT_BAD_ID, 0)});
    directed.push_back('{make_req(sfs_pkg::KIND_CREATE, 200, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         make_rsp(sfs_pkg::STAT_BAD_ID, 0)});
    directed.push_back('{make_req(sfs_pkg::KIND_DESTROY, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         make_rsp(sfs_pkg::STAT_BAD_ID, 0)});
    directed.push_back('{make_req(sfs_pkg::KIND_RECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         make_rsp(sfs_pkg::STAT_BAD_ID, 0)});
    directed.push_back('{make_req(sfs_pkg::KIND_STOPQ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         make_rsp(sfs_pkg::STAT_BAD_ID, 0)});
    directed.push_back('{make_req(sfs_pkg::KIND_REG, 0, 12'hFFF, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         make_rsp(sfs_pkg::STAT_OK, 0)});
    directed.push_back('{make_req(sfs_pkg::KIND_REG, 0, 0, 9'h1FF, 9'd256, 32'hFFFF_FFFF,
                         12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1), 1,
                         make_rsp(sfs_pkg::STAT_OK, 1)});
    directed.push_back('{make_req(sfs_pkg::KIND_REG, 0, 12'h5A5, 3, 2, 32'h1_0000,
                         12'd16, 12'd24, 12'd8, 12'd4, 0), 1,
                         make_rsp(sfs_pkg::STAT_OK, 2)});
    directed.push_back('{make_req(sfs_pkg::KIND_CREATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         make_rsp(sfs_pkg::STAT_OK, 0)});
    directed.push_back('{make_req(sfs_pkg::KIND_RECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         make_rsp(sfs_pkg::STAT_ZERO_COLS, 0)});
    directed.push_back('{make_req(sfs_pkg::KIND_CREATE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         make_rsp(sfs_pkg::STAT_OK, 1)});
    directed.push_back('{make_req(sfs_pkg::KIND_CREATE, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         make_rsp(sfs_pkg::STAT_OK, 2)});
    directed.push_back('{make_req(sfs_pkg::KIND_TICK, 0, 0, 0, 0, 32'h1_0000, 0, 0, 0, 0, 0),
                         0, '0});
    for (int i = 0; i < 5; i++)
      directed.push_back('{make_req(sfs_pkg::KIND_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF,
                                    0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{make_req(sfs_pkg::KIND_RECT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{make_req(sfs_pkg::KIND_RECT, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{make_req(sfs_pkg::KIND_STOPQ, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{make_req(sfs_pkg::KIND_DESTROY, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         make_rsp(sfs_pkg::STAT_OK, 0)});
    directed.push_back('{make_req(sfs_pkg::KIND_STOPQ, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         make_rsp(sfs_pkg::STAT_BAD_ID, 0)});

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].rsp);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 0 && n == 100) hold_req = 1'b1;
        if (ph == 2 && n == 200) wait_drained();
        if (n % 120 >= 100) idle_sender();
        else if (n % 120 < 40 || ph != 0) idle_sender();
        send_request(random_req(), 1'b0, '0);
      end
      wait_drained();
    end

    req_if.valid = 1'b0;
    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("Ran %0d requests including %0d ticks under four handshake mixes.", n_req, n_tick);
    $display("Saw %0d full-table refusals, %0d zero-column queries, %0d stopped players.",
             n_full, n_zero_cols, n_stopped);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hdl
hdl/sfs_pkg.sv
hdl/sfs_stream_if.sv
hdl/sfs_divider.sv
hdl/sfs_ctrl.sv
hdl/sfs_datapath.sv
hdl/sprite_frame_sequencer.sv
tb/sv/testbench.sv
